/* hw/rtl/flc_pkg.sv */
`timescale 1ns / 1ps
// flc_pkg: shared types and constants for the free-look camera update block.
// Field widths, command and direction codes, reset values, sine series constants.
// No dependencies.
package flc_pkg;

    localparam int ANGLE_W = 16;
    localparam int VEC_W   = 16;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 24;
    localparam int DIR_W   = 3;

    // angle units: 1/64 degree
    localparam int TURN_UNITS    = 23040;
    localparam int QUARTER_UNITS = 5760;
    localparam int HALF_TURN     = 11520;
    localparam int MW            = $clog2(TURN_UNITS);

    // four lookups per orient word
    localparam int ANGLE_LANES = 4;
    localparam int LANE_SY     = 0;
    localparam int LANE_CY     = 1;
    localparam int LANE_SP     = 2;
    localparam int LANE_CP     = 3;

    // sine series, Q30
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [VEC_W-1:0] vec_comp_t;
    typedef logic signed [POS_W-1:0] pos_t;

    localparam vec_comp_t UNIT_Q14    = 16'sd16384;
    localparam vec_comp_t VEC_ZERO    = 16'sd0;
    localparam pos_t      POS_ZERO    = 32'sd0;
    localparam pos_t      POS_Z_RESET = 32'sd655360;
    localparam pos_t      POS_MAX     = 32'sh7FFF_FFFF;
    localparam pos_t      POS_MIN     = 32'sh8000_0000;

    typedef enum logic {
        CMD_ORIENT = 1'b0,
        CMD_MOVE   = 1'b1
    } cmd_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_FWD   = 3'd0,
        DIR_BACK  = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_RIGHT = 3'd3,
        DIR_NONE  = 3'd4
    } dir_t;

    // per-word control carried down the pipe
    typedef struct packed {
        cmd_t                        cmd;
        dir_t                        dir;
        logic signed [SPEED_W-1:0]   speed;
    } ctl_t;

endpackage

/* hw/rtl/flc_sine_rom.sv */
`timescale 1ns / 1ps
// flc_sine_rom: full-turn sine table in Q2.14, two registered read ports.
// Contents built at elaboration from a quarter-wave Horner series. Uses flc_pkg.
module flc_sine_rom import flc_pkg::*; #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] addr_a,
    input  logic [AW-1:0] addr_b,
    output vec_comp_t     data_a,
    output vec_comp_t     data_b
);

    // phase k*2^32/DEPTH -> sin, truncated Q30 series, rounded to Q14
    function automatic vec_comp_t sine_entry(input longint unsigned phase);
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        logic [1:0]      quad;
        quad  = phase[31:30];
        f     = phase & (Q30_ONE - 64'd1);
        if (quad[0]) begin
            f = Q30_ONE - f;
        end
        x  = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (s + 64'd32768) >> 16;
        if (r > 64'd16384) begin
            r = 64'd16384;
        end
        return quad[1] ? -VEC_W'(r) : VEC_W'(r);
    endfunction

    vec_comp_t rom_mem [DEPTH];
    vec_comp_t rd_a_reg;
    vec_comp_t rd_b_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam longint unsigned PHASE = (longint'(k) << 32) / longint'(DEPTH);
        localparam vec_comp_t       ENTRY = sine_entry(PHASE);
        assign rom_mem[k] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= rom_mem[addr_a];
            rd_b_reg <= rom_mem[addr_b];
        end
    end

    assign data_a = rd_a_reg;
    assign data_b = rd_b_reg;

endmodule

/* hw/rtl/free_look_camera_vector_update.sv */
`timescale 1ns / 1ps
// free_look_camera_vector_update: camera position / front / right vector unit.
// Registers in order: input reg, angle reduce, reciprocal divide, sine ROM read,
// vector/delta, output reg; m_tvalid rises when a word reaches the output reg.
// Throughput: one word per cycle; each stage stalls only when its successor is full.
// Reset (aresetn low, synchronous): pipeline empty, position (0, 0, 10.0),
// front (0, 0, 1.0), right (1.0, 0, 0). Depends on flc_pkg, flc_sine_rom.
module free_look_camera_vector_update import flc_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // yaw_angle[15:0], pitch_angle[31:16], move_dir[34:32],
                                    // speed[58:35], zero[63:59]
    input  logic         s_tuser,   // cmd: 0 orient, 1 move
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata    // pos_x[31:0], pos_y[63:32], pos_z[95:64],
                                    // front_x[111:96], front_y[127:112], front_z[143:128],
                                    // right_x[159:144], right_z[175:160]
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int QW = AW + 1;
    // n = m * DEPTH + half turn stays below 2^NW
    localparam int NW = $clog2(TURN_UNITS * SINE_TABLE_DEPTH);
    // rounded-up reciprocal of the turn; with SH = NW + 15 the quotient is exact over n
    localparam int SH = NW + 15;
    localparam int RW = NW + 1;
    localparam longint unsigned RECIP = ((64'd1 << SH) / TURN_UNITS) + 64'd1;
    localparam int PW = NW + RW;
    localparam int MP_W = SPEED_W + VEC_W;
    localparam int DW = SPEED_W + 2;   // rounded move delta, magnitude up to 2^23
    localparam int SW = POS_W + 2;

    // ---------------------------------------------------------------------
    // Handshake: each stage loads when it is empty or its successor moves.
    // ---------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6     = !m_valid_reg  || m_tready;
    assign rdy5     = !s5_valid_reg || rdy6;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5) begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (rdy6) begin
                m_valid_reg <= s5_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] s1_yaw_reg;
    logic signed [ANGLE_W-1:0] s1_pitch_reg;
    ctl_t                      s1_ctl_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_yaw_reg       <= s_tdata[15:0];
            s1_pitch_reg     <= s_tdata[31:16];
            s1_ctl_reg.cmd   <= cmd_t'(s_tuser);
            s1_ctl_reg.dir   <= dir_t'(s_tdata[34:32]);
            s1_ctl_reg.speed <= s_tdata[58:35];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: reduce each angle into one turn, scale by table depth.
    // Cosine is the sine a quarter turn ahead.
    // ---------------------------------------------------------------------
    function automatic logic [MW-1:0] turn_reduce(input logic signed [ANGLE_W:0] a);
        logic [ANGLE_W+1:0] v;
        // bias by two turns so the value is positive, then strip whole turns
        v = (ANGLE_W+2)'((ANGLE_W+2)'(a) + (ANGLE_W+2)'(2 * TURN_UNITS));
        priority if (v >= (ANGLE_W+2)'(3 * TURN_UNITS)) begin
            return MW'(v - (ANGLE_W+2)'(3 * TURN_UNITS));
        end else if (v >= (ANGLE_W+2)'(2 * TURN_UNITS)) begin
            return MW'(v - (ANGLE_W+2)'(2 * TURN_UNITS));
        end else if (v >= (ANGLE_W+2)'(TURN_UNITS)) begin
            return MW'(v - (ANGLE_W+2)'(TURN_UNITS));
        end else begin
            return MW'(v);
        end
    endfunction

    logic signed [ANGLE_W:0] ang [ANGLE_LANES];
    logic [NW-1:0]           n_next [ANGLE_LANES];
    logic [NW-1:0]           s2_n_reg [ANGLE_LANES];
    ctl_t                    s2_ctl_reg;

    always_comb begin
        ang[LANE_SY] = (ANGLE_W+1)'(s1_yaw_reg);
        ang[LANE_CY] = (ANGLE_W+1)'(s1_yaw_reg) + (ANGLE_W+1)'(QUARTER_UNITS);
        ang[LANE_SP] = (ANGLE_W+1)'(s1_pitch_reg);
        ang[LANE_CP] = (ANGLE_W+1)'(s1_pitch_reg) + (ANGLE_W+1)'(QUARTER_UNITS);
        for (int l = 0; l < ANGLE_LANES; l++) begin
            n_next[l] = NW'(turn_reduce(ang[l])) * NW'(SINE_TABLE_DEPTH) + NW'(HALF_TURN);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_n_reg   <= n_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: table index = n / turn via reciprocal multiply (index in [0, DEPTH])
    // ---------------------------------------------------------------------
    logic [PW-1:0] prod [ANGLE_LANES];
    logic [QW-1:0] q_next [ANGLE_LANES];
    logic [QW-1:0] s3_q_reg [ANGLE_LANES];
    ctl_t          s3_ctl_reg;

    always_comb begin
        for (int l = 0; l < ANGLE_LANES; l++) begin
            prod[l]   = PW'(s2_n_reg[l]) * PW'(RECIP);
            q_next[l] = QW'(prod[l] >> SH);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_q_reg   <= q_next;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: wrap the index at full depth, registered ROM read
    // ---------------------------------------------------------------------
    logic [AW-1:0] idx [ANGLE_LANES];
    vec_comp_t     sy, cy, sp, cp;
    ctl_t          s4_ctl_reg;

    always_comb begin
        for (int l = 0; l < ANGLE_LANES; l++) begin
            if (s3_q_reg[l] >= QW'(SINE_TABLE_DEPTH)) begin
                idx[l] = AW'(s3_q_reg[l] - QW'(SINE_TABLE_DEPTH));
            end else begin
                idx[l] = AW'(s3_q_reg[l]);
            end
        end
    end

    flc_sine_rom #(
        .DEPTH  (SINE_TABLE_DEPTH)
    ) u_rom_yaw (
        .aclk   (aclk),
        .rd_en  (rdy4),
        .addr_a (idx[LANE_SY]),
        .addr_b (idx[LANE_CY]),
        .data_a (sy),
        .data_b (cy)
    );

    flc_sine_rom #(
        .DEPTH  (SINE_TABLE_DEPTH)
    ) u_rom_pitch (
        .aclk   (aclk),
        .rd_en  (rdy4),
        .addr_a (idx[LANE_SP]),
        .addr_b (idx[LANE_CP]),
        .data_a (sp),
        .data_b (cp)
    );

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: orient words write front/right; move words form the delta
    // from the vectors as they stand (earlier orients already written).
    // ---------------------------------------------------------------------
    vec_comp_t front_x_reg, front_y_reg, front_z_reg;
    vec_comp_t right_x_reg, right_z_reg;
    logic signed [2*VEC_W-1:0] p_fx, p_fz;
    vec_comp_t fx_next, fz_next, rx_next, rz_next;
    logic      orient_wr;

    always_comb begin
        p_fx    = (2*VEC_W)'(cy) * (2*VEC_W)'(cp);
        p_fz    = (2*VEC_W)'(sy) * (2*VEC_W)'(cp);
        fx_next = VEC_W'((p_fx + (2*VEC_W)'(8192)) >>> 14);
        fz_next = VEC_W'((p_fz + (2*VEC_W)'(8192)) >>> 14);
        // right = (-sin yaw, 0, cos yaw) * sign(cos pitch), zero at a pole
        if (cp > VEC_ZERO) begin
            rx_next = -sy;
            rz_next = cy;
        end else if (cp < VEC_ZERO) begin
            rx_next = sy;
            rz_next = -cy;
        end else begin
            rx_next = VEC_ZERO;
            rz_next = VEC_ZERO;
        end
    end

    assign orient_wr = rdy5 && s4_valid_reg && (s4_ctl_reg.cmd == CMD_ORIENT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_x_reg <= VEC_ZERO;
            front_y_reg <= VEC_ZERO;
            front_z_reg <= UNIT_Q14;
            right_x_reg <= UNIT_Q14;
            right_z_reg <= VEC_ZERO;
        end else if (orient_wr) begin
            front_x_reg <= fx_next;
            front_y_reg <= sp;
            front_z_reg <= fz_next;
            right_x_reg <= rx_next;
            right_z_reg <= rz_next;
        end
    end

    vec_comp_t              mv_vec [3];
    logic                   mv_en, mv_sub;
    logic signed [MP_W-1:0] mv_prod [3];
    logic signed [DW-1:0]   delta_next [3];
    logic signed [DW-1:0]   s5_delta_reg [3];
    logic                   s5_move_reg;
    logic                   s5_sub_reg;

    always_comb begin
        mv_en  = 1'b1;
        mv_sub = 1'b0;
        unique case (s4_ctl_reg.dir)
            DIR_FWD: begin
                mv_vec = '{front_x_reg, front_y_reg, front_z_reg};
            end
            DIR_BACK: begin
                mv_vec = '{front_x_reg, front_y_reg, front_z_reg};
                mv_sub = 1'b1;
            end
            DIR_LEFT: begin
                mv_vec = '{right_x_reg, VEC_ZERO, right_z_reg};
                mv_sub = 1'b1;
            end
            DIR_RIGHT: begin
                mv_vec = '{right_x_reg, VEC_ZERO, right_z_reg};
            end
            default: begin
                // no movement and unused codes
                mv_vec = '{VEC_ZERO, VEC_ZERO, VEC_ZERO};
                mv_en  = 1'b0;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            mv_prod[i]    = MP_W'(s4_ctl_reg.speed) * MP_W'(mv_vec[i]);
            delta_next[i] = DW'((mv_prod[i] + MP_W'(8192)) >>> 14);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            s5_delta_reg <= delta_next;
            s5_move_reg  <= (s4_ctl_reg.cmd == CMD_MOVE) && mv_en;
            s5_sub_reg   <= mv_sub;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: saturating position update and output register
    // ---------------------------------------------------------------------
    function automatic pos_t sat_step(input pos_t p, input logic signed [DW-1:0] d,
                                      input logic sub);
        logic signed [SW-1:0] w;
        if (sub) begin
            w = SW'(p) - SW'(d);
        end else begin
            w = SW'(p) + SW'(d);
        end
        priority if (w > SW'(POS_MAX)) begin
            return POS_MAX;
        end else if (w < SW'(POS_MIN)) begin
            return POS_MIN;
        end else begin
            return POS_W'(w);
        end
    endfunction

    pos_t pos_reg [3];
    pos_t pos_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (s5_valid_reg && s5_move_reg) begin
                pos_next[i] = sat_step(pos_reg[i], s5_delta_reg[i], s5_sub_reg);
            end else begin
                pos_next[i] = pos_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg[0] <= POS_ZERO;
            pos_reg[1] <= POS_ZERO;
            pos_reg[2] <= POS_Z_RESET;
        end else if (rdy6) begin
            pos_reg <= pos_next;
        end
    end

    pos_t      out_pos_reg [3];
    vec_comp_t out_fx_reg, out_fy_reg, out_fz_reg, out_rx_reg, out_rz_reg;

    // vectors as they stand now: this word's own orient, none later yet
    always_ff @(posedge aclk) begin
        if (rdy6) begin
            out_pos_reg <= pos_next;
            out_fx_reg  <= front_x_reg;
            out_fy_reg  <= front_y_reg;
            out_fz_reg  <= front_z_reg;
            out_rx_reg  <= right_x_reg;
            out_rz_reg  <= right_z_reg;
        end
    end

    assign m_tdata = {out_rz_reg, out_rx_reg, out_fz_reg, out_fy_reg, out_fx_reg,
                      out_pos_reg[2], out_pos_reg[1], out_pos_reg[0]};

endmodule

/* sim/tb_free_look_camera_vector_update.sv */
`timescale 1ns / 1ps
// tb_free_look_camera_vector_update: self-checking bench for the camera vector unit.
// Predicts position/front/right per input word and compares every result word.
// Depends on flc_pkg and free_look_camera_vector_update.
module tb_free_look_camera_vector_update;
    import flc_pkg::*;

    localparam int SINE_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_CYCLES = 150;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;

    // result word, pos_x in the lowest bits
    typedef struct packed {
        vec_comp_t right_z;
        vec_comp_t right_x;
        vec_comp_t front_z;
        vec_comp_t front_y;
        vec_comp_t front_x;
        pos_t      pos_z;
        pos_t      pos_y;
        pos_t      pos_x;
    } cam_view_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;

    free_look_camera_vector_update #(
        .SINE_TABLE_DEPTH(SINE_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // camera state as the bench sees it
    int        sine_lut [SINE_DEPTH];
    pos_t      cam_pos [3];
    vec_comp_t cam_front [3];
    vec_comp_t cam_right [3];
    cam_view_t pending_views [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit no_idle        = 1'b0;
    bit hold_req       = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    // sine of k/DEPTH of a turn in Q2.14, quarter-wave Horner series in Q30
    function automatic int rom_sine(int k);
        longint unsigned phase, f, x, x2, t, s, r;
        int quad;
        phase = (64'(k) << 32) / 64'(SINE_DEPTH);
        quad  = int'((phase >> 30) & 64'd3);
        f     = phase & (Q30_ONE - 64'd1);
        if (quad[0])
            f = Q30_ONE - f;
        x  = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (s + 64'd32768) >> 16;
        if (r > 64'd16384)
            r = 64'd16384;
        return (quad >= 2) ? -int'(r) : int'(r);
    endfunction

    function automatic int sine_of_angle(int a);
        int m, idx;
        m = a % TURN_UNITS;
        if (m < 0)
            m += TURN_UNITS;
        idx = (m * SINE_DEPTH + TURN_UNITS / 2) / TURN_UNITS;
        if (idx >= SINE_DEPTH)
            idx -= SINE_DEPTH;
        return sine_lut[idx];
    endfunction

    // floor((p + 8192) / 16384)
    function automatic longint round_q14(longint p);
        return (p + 64'sd8192) >>> 14;
    endfunction

    function automatic void shift_position(vec_comp_t vx, vec_comp_t vy, vec_comp_t vz,
                                           logic signed [SPEED_W-1:0] spd, bit sub);
        vec_comp_t v [3];
        longint d, n;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        for (int i = 0; i < 3; i++) begin
            d = round_q14(longint'(spd) * longint'(v[i]));
            n = sub ? longint'(cam_pos[i]) - d : longint'(cam_pos[i]) + d;
            if (n > longint'(POS_MAX))
                cam_pos[i] = POS_MAX;
            else if (n < longint'(POS_MIN))
                cam_pos[i] = POS_MIN;
            else
                cam_pos[i] = pos_t'(n);
        end
    endfunction

    function automatic cam_view_t predict_view(cmd_t c, logic signed [15:0] yaw,
                                               logic signed [15:0] pitch, logic [2:0] dir,
                                               logic signed [SPEED_W-1:0] spd);
        int sy, cy, sp, cp;
        cam_view_t v;
        if (c == CMD_ORIENT) begin
            sy = sine_of_angle(int'(yaw));
            cy = sine_of_angle(int'(yaw) + QUARTER_UNITS);
            sp = sine_of_angle(int'(pitch));
            cp = sine_of_angle(int'(pitch) + QUARTER_UNITS);
            cam_front[0] = vec_comp_t'(round_q14(longint'(cy) * longint'(cp)));
            cam_front[1] = vec_comp_t'(sp);
            cam_front[2] = vec_comp_t'(round_q14(longint'(sy) * longint'(cp)));
            // right flips with the sign of cos pitch, vanishes at a pole
            if (cp > 0) begin
                cam_right[0] = vec_comp_t'(-sy);
                cam_right[2] = vec_comp_t'(cy);
            end else if (cp < 0) begin
                cam_right[0] = vec_comp_t'(sy);
                cam_right[2] = vec_comp_t'(-cy);
            end else begin
                cam_right[0] = VEC_ZERO;
                cam_right[2] = VEC_ZERO;
            end
        end else begin
            case (dir)
                DIR_FWD:   shift_position(cam_front[0], cam_front[1], cam_front[2], spd, 1'b0);
                DIR_BACK:  shift_position(cam_front[0], cam_front[1], cam_front[2], spd, 1'b1);
                DIR_LEFT:  shift_position(cam_right[0], cam_right[1], cam_right[2], spd, 1'b1);
                DIR_RIGHT: shift_position(cam_right[0], cam_right[1], cam_right[2], spd, 1'b0);
                default: ;
            endcase
        end
        v.pos_x   = cam_pos[0];
        v.pos_y   = cam_pos[1];
        v.pos_z   = cam_pos[2];
        v.front_x = cam_front[0];
        v.front_y = cam_front[1];
        v.front_z = cam_front[2];
        v.right_x = cam_right[0];
        v.right_z = cam_right[2];
        return v;
    endfunction

    // ---------------- input side ----------------

    // Called right after the clock rises; valid stays high into the next word
    // unless a gap is drawn.
    task automatic send_word(input cmd_t c, input logic signed [15:0] yaw,
                             input logic signed [15:0] pitch, input logic [2:0] dir,
                             input logic signed [SPEED_W-1:0] spd);
        while (!no_idle && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {5'd0, spd, dir, pitch, yaw};
        do @(posedge aclk); while (!s_tready);
        pending_views.push_back(predict_view(c, yaw, pitch, dir, spd));
    endtask

    // ---------------- output side ----------------

    initial begin : ready_driver
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            // start the hold once when the request goes up
            if (hold_req && !hold_seen) begin
                hold_left = HOLD_CYCLES;
            end
            hold_seen = hold_req;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 23);
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("MISMATCH %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        cam_view_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = cam_view_t'(m_tdata);
            if (pending_views.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("UNEXPECTED result word %h", m_tdata);
            end else begin
                want = pending_views.pop_front();
                check_field("pos_x",   want.pos_x,   got.pos_x);
                check_field("pos_y",   want.pos_y,   got.pos_y);
                check_field("pos_z",   want.pos_z,   got.pos_z);
                check_field("front_x", want.front_x, got.front_x);
                check_field("front_y", want.front_y, got.front_y);
                check_field("front_z", want.front_z, got.front_z);
                check_field("right_x", want.right_x, got.right_x);
                check_field("right_z", want.right_z, got.right_z);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // reset state, every direction, angle extremes, poles, ignored fields
    task automatic test_directed();
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_NONE, 24'sd0);
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_FWD, SPEED_MAX);
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_BACK, SPEED_MIN);
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_LEFT, SPEED_MAX);
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_RIGHT, -24'sd1);
        // unused direction codes leave the position alone
        for (int d = DIR_NONE + 1; d < 8; d++)
            send_word(CMD_MOVE, 16'sh7FFF, 16'sh8000, 3'(d), SPEED_MAX);
        send_word(CMD_ORIENT, 16'sd0, 16'sd0, DIR_FWD, SPEED_MAX);
        send_word(CMD_ORIENT, 16'sh8000, 16'sh7FFF, DIR_RIGHT, SPEED_MIN);
        send_word(CMD_ORIENT, 16'sd23039, -16'sd23040, DIR_NONE, 24'sd0);
        send_word(CMD_ORIENT, 16'sd5760, -16'sd11520, DIR_FWD, 24'sd0);
        // cos pitch negative: right flips
        send_word(CMD_ORIENT, -16'sd2000, 16'sd11520, DIR_FWD, 24'sd0);
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_LEFT, 24'sd65536);
        // poles: right collapses to zero
        send_word(CMD_ORIENT, 16'sd1234, 16'sd5760, DIR_FWD, 24'sd0);
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_RIGHT, SPEED_MAX);
        send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_FWD, 24'sd65536);
        send_word(CMD_ORIENT, -16'sd4321, -16'sd5760, DIR_BACK, SPEED_MIN);
        send_word(CMD_MOVE, 16'sh7FFF, 16'sh8000, DIR_BACK, SPEED_MIN);
    endtask

    // receiver holds off while words keep coming, so the pipe fills and s_tready drops
    task automatic test_backpressure();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_word(cmd_t'($urandom_range(1)), 16'($urandom()), 16'($urandom()),
                      3'($urandom_range(DIR_NONE)), 24'($urandom()));
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int kind;
        logic signed [15:0] yaw, pitch;
        logic [2:0] dir;
        logic signed [SPEED_W-1:0] spd;
        no_idle = 1'b1;
        for (int n = 0; n < 140; n++) begin
            if (n == 60)
                no_idle = 1'b0;
            kind = $urandom_range(99);
            if ($urandom_range(1)) begin
                yaw   = 16'($urandom_range(2 * TURN_UNITS - 1) - TURN_UNITS);
                pitch = 16'($urandom_range(2 * TURN_UNITS - 1) - TURN_UNITS);
            end else begin
                yaw   = 16'($urandom());
                pitch = 16'($urandom());
            end
            if ($urandom_range(9) == 0)
                dir = 3'($urandom_range(7, DIR_NONE));
            else
                dir = 3'($urandom_range(DIR_RIGHT));
            if ($urandom_range(1))
                spd = 24'($urandom());
            else
                spd = 24'($urandom_range(131071) - 65536);
            send_word((kind < 25) ? CMD_ORIENT : CMD_MOVE, yaw, pitch, dir, spd);
        end
    endtask

    // head down at 45 degrees: x runs to the positive rail, y to the negative rail
    task automatic test_saturation();
        send_word(CMD_ORIENT, 16'sd0, -16'(QUARTER_UNITS / 2), DIR_NONE, 24'sd0);
        for (int n = 0; n < 400; n++)
            send_word(CMD_MOVE, 16'sd0, 16'sd0, DIR_FWD, SPEED_MAX);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = CMD_ORIENT;
        s_tdata  = '0;
        for (int k = 0; k < SINE_DEPTH; k++)
            sine_lut[k] = rom_sine(k);
        cam_pos[0]   = POS_ZERO;
        cam_pos[1]   = POS_ZERO;
        cam_pos[2]   = POS_Z_RESET;
        cam_front[0] = VEC_ZERO;
        cam_front[1] = VEC_ZERO;
        cam_front[2] = UNIT_Q14;
        cam_right[0] = UNIT_Q14;
        cam_right[1] = VEC_ZERO;
        cam_right[2] = VEC_ZERO;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();
        test_saturation();

        s_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/flc_pkg.sv
hw/rtl/flc_sine_rom.sv
hw/rtl/free_look_camera_vector_update.sv
sim/tb_free_look_camera_vector_update.sv
